### design/cam_presence_and_speed_pulse_monitor_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cam presence and speed pulse monitor
// Concurrent checks on the rising edge of clock, held off during reset.
// ---------------------------------------------------------------------------
`ifndef CAM_PRESENCE_AND_SPEED_PULSE_MONITOR_UNIT_ASSERT_SVH
`define CAM_PRESENCE_AND_SPEED_PULSE_MONITOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define CPSM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define CPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CPSM_ASSERT_SAME(lbl, ante, cons, msg)
`define CPSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/cpsm_pkg.sv
// ---------------------------------------------------------------------------
// cpsm_pkg
// Types and codes shared by the cam presence and speed pulse monitor.
// ---------------------------------------------------------------------------
`default_nettype none

package cpsm_pkg;

   localparam logic [2:0] OP_REF_EDGE   = 3'd0;
   localparam logic [2:0] OP_PHASE_EDGE = 3'd1;
   localparam logic [2:0] OP_TOOTH      = 3'd2;
   localparam logic [2:0] OP_POLL       = 3'd3;
   localparam logic [2:0] OP_READ       = 3'd4;

   localparam logic [1:0] REF_ROLE_NONE  = 2'd0;
   localparam logic [1:0] REF_ROLE_REF   = 2'd1;
   localparam logic [1:0] REF_ROLE_SPEED = 2'd2;
   localparam logic [1:0] REF_ROLE_CAM   = 2'd3;

   localparam logic [1:0] PH_ROLE_NONE  = 2'd0;
   localparam logic [1:0] PH_ROLE_CAM   = 2'd1;
   localparam logic [1:0] PH_ROLE_SPEED = 2'd2;

   localparam logic [1:0] CSR_REF_ROLE   = 2'd0;
   localparam logic [1:0] CSR_PHASE_ROLE = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD  = 2'd2;
   localparam logic [1:0] CSR_CAM_WATCH  = 2'd3;

   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] STOP_GAP = 16'd62000;
   localparam logic [15:0] ALL_ONES = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] timer_value;
      logic        clear_count;
      logic        clear_error;
   } req_type;

   typedef struct packed {
      logic        ref_event;
      logic        cam_edge_seen;
      logic        cam_ready;
      logic        cam_fault;
      logic [15:0] speed_period;
      logic [15:0] pulse_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  ref_input_role;
      logic [1:0]  phase_input_role;
      logic [15:0] cam_error_threshold;
      logic        cam_watch;
   } cfg_type;

endpackage

`default_nettype wire

### design/cpsm_cfg_regs.sv
// ---------------------------------------------------------------------------
// cpsm_cfg_regs
// Configuration register file, written through the plain csr port.
// ---------------------------------------------------------------------------
`default_nettype none

module cpsm_cfg_regs (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [cpsm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output cpsm_pkg::cfg_type                       cfg
);
   import cpsm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_REF_ROLE:   cfg_in.ref_input_role      = csr_wdata[1:0];
            CSR_PHASE_ROLE: cfg_in.phase_input_role    = csr_wdata[1:0];
            CSR_THRESHOLD:  cfg_in.cam_error_threshold = csr_wdata[15:0];
            CSR_CAM_WATCH:  cfg_in.cam_watch           = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_input_role      <= REF_ROLE_REF;
         cfg_ff.phase_input_role    <= PH_ROLE_CAM;
         cfg_ff.cam_error_threshold <= '0;
         cfg_ff.cam_watch           <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### design/cpsm_core.sv
// ---------------------------------------------------------------------------
// cpsm_core
// Monitor state and the single-pass update and status snapshot per item.
// ---------------------------------------------------------------------------
`default_nettype none

module cpsm_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cpsm_pkg::cfg_type cfg,
   input  wire logic              item_valid,
   input  wire cpsm_pkg::req_type item,
   output cpsm_pkg::rsp_type      snap
);
   import cpsm_pkg::*;

   logic        ref_flag_ff,     ref_flag_in;
   logic        cam_flag_ff,     cam_flag_in;
   logic        cam_ok_ff,       cam_ok_in;
   logic        cam_err_ff,      cam_err_in;
   logic [15:0] tooth_count_ff,  tooth_count_in;
   logic [15:0] last_pulse_ff,   last_pulse_in;
   logic [15:0] raw_period_ff,   raw_period_in;
   logic        speed_flag_ff,   speed_flag_in;
   logic [15:0] held_period_ff,  held_period_in;
   logic [15:0] speed_pulses_ff, speed_pulses_in;
   logic        filter_armed_ff, filter_armed_in;

   logic        speed_used;
   logic        cam_used;
   logic        is_speed_edge;
   logic        is_cam_edge;
   logic [15:0] tooth_inc;
   logic [15:0] gap;

   always_comb begin
      speed_used = (cfg.ref_input_role == REF_ROLE_SPEED) ||
                   (cfg.phase_input_role == PH_ROLE_SPEED);
      cam_used   = (cfg.ref_input_role == REF_ROLE_CAM) ||
                   (cfg.phase_input_role == PH_ROLE_CAM);
      is_speed_edge = ((item.op == OP_REF_EDGE) && (cfg.ref_input_role == REF_ROLE_SPEED)) ||
                      ((item.op == OP_PHASE_EDGE) && (cfg.phase_input_role == PH_ROLE_SPEED));
      is_cam_edge   = ((item.op == OP_REF_EDGE) && (cfg.ref_input_role == REF_ROLE_CAM)) ||
                      ((item.op == OP_PHASE_EDGE) && (cfg.phase_input_role == PH_ROLE_CAM));
      tooth_inc = tooth_count_ff + 16'd1;
      gap       = item.timer_value - last_pulse_ff;

      ref_flag_in     = ref_flag_ff;
      cam_flag_in     = cam_flag_ff;
      cam_ok_in       = cam_ok_ff;
      cam_err_in      = cam_err_ff;
      tooth_count_in  = tooth_count_ff;
      last_pulse_in   = last_pulse_ff;
      raw_period_in   = raw_period_ff;
      speed_flag_in   = speed_flag_ff;
      held_period_in  = held_period_ff;
      speed_pulses_in = speed_pulses_ff;
      filter_armed_in = filter_armed_ff;

      if ((item.op == OP_REF_EDGE) && (cfg.ref_input_role == REF_ROLE_REF)) begin
         ref_flag_in = 1'b1;
      end
      if (is_speed_edge) begin
         speed_pulses_in = speed_pulses_ff + 16'd1;
         raw_period_in   = gap;
         last_pulse_in   = item.timer_value;
         speed_flag_in   = 1'b1;
      end
      if (is_cam_edge && cfg.cam_watch) begin
         cam_ok_in      = 1'b1;
         tooth_count_in = '0;
         cam_flag_in    = 1'b1;
      end

      case (item.op)
         OP_TOOTH: begin
            if (cam_used && cfg.cam_watch) begin
               tooth_count_in = tooth_inc;
               if (tooth_inc > cfg.cam_error_threshold) begin
                  cam_ok_in      = 1'b0;
                  cam_err_in     = 1'b1;
                  tooth_count_in = '0;
               end
            end
         end
         OP_POLL: begin
            if (speed_used) begin
               speed_flag_in = 1'b0;
               if (!filter_armed_ff) begin
                  if (speed_flag_ff) begin
                     filter_armed_in = 1'b1;
                  end
               end else if (gap > STOP_GAP) begin
                  held_period_in  = ALL_ONES;
                  filter_armed_in = 1'b0;
               end else if (speed_flag_ff) begin
                  held_period_in = raw_period_ff;
               end
            end
         end
         OP_READ: begin
            ref_flag_in = 1'b0;
            cam_flag_in = 1'b0;
            if (item.clear_count) begin
               speed_pulses_in = '0;
            end
            if (item.clear_error) begin
               cam_err_in = 1'b0;
            end
         end
         default: ;
      endcase

      if (item.op == OP_READ) begin
         snap.ref_event     = ref_flag_ff;
         snap.cam_edge_seen = cam_flag_ff;
         snap.cam_ready     = cam_ok_ff;
         snap.cam_fault     = cam_err_ff;
         snap.speed_period  = speed_used ? held_period_ff : 16'd0;
         snap.pulse_count   = speed_used ? speed_pulses_ff : 16'd0;
      end else begin
         snap.ref_event     = ref_flag_in;
         snap.cam_edge_seen = cam_flag_in;
         snap.cam_ready     = cam_ok_in;
         snap.cam_fault     = cam_err_in;
         snap.speed_period  = speed_used ? held_period_in : 16'd0;
         snap.pulse_count   = speed_used ? speed_pulses_in : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_flag_ff     <= 1'b0;
         cam_flag_ff     <= 1'b0;
         cam_ok_ff       <= 1'b0;
         cam_err_ff      <= 1'b0;
         tooth_count_ff  <= '0;
         last_pulse_ff   <= '0;
         raw_period_ff   <= ALL_ONES;
         speed_flag_ff   <= 1'b0;
         held_period_ff  <= ALL_ONES;
         speed_pulses_ff <= '0;
         filter_armed_ff <= 1'b0;
      end else if (item_valid) begin
         ref_flag_ff     <= ref_flag_in;
         cam_flag_ff     <= cam_flag_in;
         cam_ok_ff       <= cam_ok_in;
         cam_err_ff      <= cam_err_in;
         tooth_count_ff  <= tooth_count_in;
         last_pulse_ff   <= last_pulse_in;
         raw_period_ff   <= raw_period_in;
         speed_flag_ff   <= speed_flag_in;
         held_period_ff  <= held_period_in;
         speed_pulses_ff <= speed_pulses_in;
         filter_armed_ff <= filter_armed_in;
      end
   end

endmodule

`default_nettype wire

### design/cam_presence_and_speed_pulse_monitor_unit.sv
// ---------------------------------------------------------------------------
// cam_presence_and_speed_pulse_monitor_unit
// Cam presence, reference edge and speed pulse monitor with status reads.
//
// The req channel carries one event transaction (pin edge, crank tooth,
// poll tick or status read) with its timer sample. Every request yields
// exactly one rsp transaction holding the status snapshot.
// A request is captured in an input register, processed in one pass
// against the monitor state, and the snapshot lands in the result
// register that drives rsp_valid and rsp_data. Throughput is one
// transaction per cycle while the receiver does not stall; the state
// is updated in one pass, so back-to-back requests are taken without gaps.
// When the receiver stalls, the result register holds, the next request
// waits in the input register, and req_stall rises only once both are full.
// The csr port writes the role, threshold and enable registers; write
// them only while no transaction is in flight.
// Synchronous reset empties both registers, restores the register
// defaults and returns the monitor state to its idle values.
// ---------------------------------------------------------------------------
`default_nettype none

module cam_presence_and_speed_pulse_monitor_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire cpsm_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output cpsm_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_wr_en,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [cpsm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cpsm_pkg::*;

   `include "cam_presence_and_speed_pulse_monitor_unit_assert.svh"

   cfg_type cfg;
   rsp_type snap;

   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_item_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    advance;
   logic    req_take;

   cpsm_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cpsm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (advance),
      .item       (s1_item_ff),
      .snap       (snap)
   );

   always_comb begin
      advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall    = s1_valid_ff && !advance;
      req_take     = req_valid && !req_stall;
      s1_valid_in  = req_take || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= snap;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CPSM_ASSERT_SAME(a_stall_needs_item, req_stall, s1_valid_ff, "stall with empty input stage")
   `CPSM_ASSERT_SAME(a_empty_out_no_stall, !rsp_valid_ff, !req_stall, "stall with free result")
   `CPSM_ASSERT_NEXT(a_advance_fills_out, advance, rsp_valid_ff, "processed item not presented")

endmodule

`default_nettype wire
